// ----- design/rth_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

    // Default number of fraction bits on hue and saturation
    localparam int FRACTION_BITS_DEFAULT = 6;

    // Integer bits of the hue quotient: hue stays below 360 < 2**9
    localparam int HUE_INT_BITS = 9;

    localparam int CHANNEL_WIDTH = 8;
    localparam int HUE_WIDTH     = 15;
    localparam int SAT_WIDTH     = 14;

    localparam int DEG_PER_SECTOR = 60;
    localparam int GREEN_OFFSET   = 120;
    localparam int BLUE_OFFSET    = 240;
    localparam int FULL_TURN      = 360;
    localparam int SAT_SCALE      = 255;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

endpackage

// ----- design/rgb_to_hsv_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB pixel to hue, saturation and value, fully pipelined.
// ----------------------------------------------------------------------------
// One pixel is taken every clock while pixel_stall is low, and one HSV result
// comes out for each. Two front stages find max, min, sector and the hue and
// saturation dividends, then a restoring divider pair retires one quotient
// bit per stage. The last divider stage is the output register; stalls back
// up only as far as the pipe is full, so bubbles are squeezed out while the
// output waits. A gray pixel gives hue 0, saturation 0 and gray_flag set.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter
    import rth_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pixel_valid,
    output logic                     pixel_stall,
    input  logic [CHANNEL_WIDTH-1:0] red,
    input  logic [CHANNEL_WIDTH-1:0] green,
    input  logic [CHANNEL_WIDTH-1:0] blue,
    output logic                     hsv_valid,
    input  logic                     hsv_stall,
    output logic [HUE_WIDTH-1:0]     hue,
    output logic [SAT_WIDTH-1:0]     saturation,
    output logic [CHANNEL_WIDTH-1:0] brightness,
    output logic                     gray_flag
);

    localparam int QW = HUE_INT_BITS + FRACTION_BITS;
    localparam int CW = CHANNEL_WIDTH;

    // Stage 1: extremes and sector
    logic                s1_valid_reg;
    logic                s1_gray_reg;
    logic [CW-1:0]       s1_hi_reg;
    logic [CW-1:0]       s1_delta_reg;
    sector_t             s1_sector_reg;
    logic signed [CW:0]  s1_diff_reg;

    logic                s1_gray_next;
    logic [CW-1:0]       s1_hi_next;
    logic [CW-1:0]       s1_lo_next;
    logic [CW-1:0]       s1_delta_next;
    sector_t             s1_sector_next;
    logic signed [CW:0]  s1_diff_next;

    // Stage 2: dividends and divisors
    logic                s2_valid_reg;
    logic                s2_gray_reg;
    logic [CW-1:0]       s2_bright_reg;
    logic [CW-1:0]       s2_hrem_reg;
    logic [QW-1:0]       s2_hlow_reg;
    logic [CW-1:0]       s2_hdiv_reg;
    logic [CW-1:0]       s2_srem_reg;
    logic [QW-1:0]       s2_slow_reg;
    logic [CW-1:0]       s2_sdiv_reg;

    logic signed [17:0]  diff_term;
    logic [16:0]         offset_term;
    logic [17:0]         num_wide;
    logic [16:0]         num;
    logic [15:0]         sat_prod;
    logic [CW-1:0]       s2_hrem_next;
    logic [QW-1:0]       s2_hlow_next;
    logic [CW-1:0]       s2_hdiv_next;
    logic [CW-1:0]       s2_srem_next;
    logic [QW-1:0]       s2_slow_next;
    logic [CW-1:0]       s2_sdiv_next;

    logic                div_stall;
    logic                s1_ready;
    logic                s2_ready;

    logic [QW-1:0]       hue_q;
    logic [QW-1:0]       sat_q;
    logic [31:0]         hue_full;
    logic [31:0]         sat_full;

    assign s2_ready    = !s2_valid_reg || !div_stall;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel_stall = !s1_ready;

    // Ties keep the earlier channel
    always_comb
    begin
        s1_gray_next   = (red == green) && (green == blue);
        s1_hi_next     = red;
        s1_sector_next = SECTOR_RED;
        if (red < green)
        begin
            s1_hi_next     = green;
            s1_sector_next = SECTOR_GREEN;
        end
        if (s1_hi_next < blue)
        begin
            s1_hi_next     = blue;
            s1_sector_next = SECTOR_BLUE;
        end
        s1_lo_next = red;
        if (s1_lo_next > green)
        begin
            s1_lo_next = green;
        end
        if (s1_lo_next > blue)
        begin
            s1_lo_next = blue;
        end
        s1_delta_next = s1_hi_next - s1_lo_next;
        case (s1_sector_next)
            SECTOR_RED:   s1_diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
            SECTOR_GREEN: s1_diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
            SECTOR_BLUE:  s1_diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
            default:      s1_diff_next = '0;
        endcase
    end

    // Hue numerator 60*diff + offset*delta, wrapped into one full turn
    always_comb
    begin
        diff_term = 18'(s1_diff_reg) * 18'(DEG_PER_SECTOR);
        case (s1_sector_reg)
            SECTOR_RED:   offset_term = s1_diff_reg[CW]
                                        ? 17'(FULL_TURN * s1_delta_reg) : '0;
            SECTOR_GREEN: offset_term = 17'(GREEN_OFFSET * s1_delta_reg);
            SECTOR_BLUE:  offset_term = 17'(BLUE_OFFSET * s1_delta_reg);
            default:      offset_term = '0;
        endcase
        num_wide = 18'(diff_term) + 18'(offset_term);
        num      = num_wide[16:0];
        sat_prod = 16'(SAT_SCALE * s1_delta_reg);

        // Split each dividend so the seeded remainder is below its divisor
        if (s1_gray_reg)
        begin
            s2_hrem_next = '0;
            s2_hlow_next = '0;
            s2_hdiv_next = CW'(1);
            s2_srem_next = '0;
            s2_slow_next = '0;
            s2_sdiv_next = CW'(1);
        end
        else
        begin
            s2_hrem_next = num[16:HUE_INT_BITS];
            s2_hlow_next = QW'(num[HUE_INT_BITS-1:0]) << FRACTION_BITS;
            s2_hdiv_next = s1_delta_reg;
            s2_srem_next = {1'b0, sat_prod[15:HUE_INT_BITS]};
            s2_slow_next = QW'(sat_prod[HUE_INT_BITS-1:0]) << FRACTION_BITS;
            s2_sdiv_next = s1_hi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_gray_reg   <= s1_gray_next;
            s1_hi_reg     <= s1_hi_next;
            s1_delta_reg  <= s1_delta_next;
            s1_sector_reg <= s1_sector_next;
            s1_diff_reg   <= s1_diff_next;
        end
        if (s2_ready)
        begin
            s2_gray_reg   <= s1_gray_reg;
            s2_bright_reg <= s1_hi_reg;
            s2_hrem_reg   <= s2_hrem_next;
            s2_hlow_reg   <= s2_hlow_next;
            s2_hdiv_reg   <= s2_hdiv_next;
            s2_srem_reg   <= s2_srem_next;
            s2_slow_reg   <= s2_slow_next;
            s2_sdiv_reg   <= s2_sdiv_next;
        end
    end

    rth_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s2_valid_reg),
        .up_stall   (div_stall),
        .hue_rem    (s2_hrem_reg),
        .hue_low    (s2_hlow_reg),
        .hue_div    (s2_hdiv_reg),
        .sat_rem    (s2_srem_reg),
        .sat_low    (s2_slow_reg),
        .sat_div    (s2_sdiv_reg),
        .bright_in  (s2_bright_reg),
        .gray_in    (s2_gray_reg),
        .dn_valid   (hsv_valid),
        .dn_stall   (hsv_stall),
        .hue_q      (hue_q),
        .sat_q      (sat_q),
        .bright_out (brightness),
        .gray_out   (gray_flag)
    );

    // Drop quotient bits above the field widths
    assign hue_full   = 32'(hue_q);
    assign sat_full   = 32'(sat_q);
    assign hue        = hue_full[HUE_WIDTH-1:0];
    assign saturation = sat_full[SAT_WIDTH-1:0];

endmodule

// ----- design/rth_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rth_divider
// Pipelined restoring divider pair, one quotient bit per stage, for hue and
// saturation. Pixel sideband travels with the quotients.
// ----------------------------------------------------------------------------
module rth_divider
    import rth_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_stall,
    input  logic [CHANNEL_WIDTH-1:0]      hue_rem,
    input  logic [HUE_INT_BITS+FRACTION_BITS-1:0] hue_low,
    input  logic [CHANNEL_WIDTH-1:0]      hue_div,
    input  logic [CHANNEL_WIDTH-1:0]      sat_rem,
    input  logic [HUE_INT_BITS+FRACTION_BITS-1:0] sat_low,
    input  logic [CHANNEL_WIDTH-1:0]      sat_div,
    input  logic [CHANNEL_WIDTH-1:0]      bright_in,
    input  logic                          gray_in,
    output logic                          dn_valid,
    input  logic                          dn_stall,
    output logic [HUE_INT_BITS+FRACTION_BITS-1:0] hue_q,
    output logic [HUE_INT_BITS+FRACTION_BITS-1:0] sat_q,
    output logic [CHANNEL_WIDTH-1:0]      bright_out,
    output logic                          gray_out
);

    localparam int QW = HUE_INT_BITS + FRACTION_BITS;
    localparam int NS = QW;
    localparam int CW = CHANNEL_WIDTH;

    logic [NS-1:0] valid_reg;
    logic [CW-1:0] h_rem_reg  [NS];
    logic [QW-1:0] h_word_reg [NS];
    logic [CW-1:0] h_div_reg  [NS];
    logic [CW-1:0] s_rem_reg  [NS];
    logic [QW-1:0] s_word_reg [NS];
    logic [CW-1:0] s_div_reg  [NS];
    logic [CW-1:0] bright_reg [NS];
    logic [NS-1:0] gray_reg;

    logic [NS-1:0] valid_src;
    logic [CW-1:0] h_rem_src  [NS];
    logic [QW-1:0] h_word_src [NS];
    logic [CW-1:0] h_div_src  [NS];
    logic [CW-1:0] s_rem_src  [NS];
    logic [QW-1:0] s_word_src [NS];
    logic [CW-1:0] s_div_src  [NS];
    logic [CW-1:0] bright_src [NS];
    logic [NS-1:0] gray_src;

    logic [CW:0]   h_trial    [NS];
    logic [CW:0]   s_trial    [NS];
    logic [NS-1:0] h_ge;
    logic [NS-1:0] s_ge;
    logic [CW-1:0] h_rem_next  [NS];
    logic [QW-1:0] h_word_next [NS];
    logic [CW-1:0] s_rem_next  [NS];
    logic [QW-1:0] s_word_next [NS];

    logic [NS:0]   ready;

    // A stage may load when empty or when the stage after it moves
    always_comb
    begin
        ready[NS] = !dn_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign up_stall = !ready[0];

    always_comb
    begin
        valid_src[0]  = up_valid;
        h_rem_src[0]  = hue_rem;
        h_word_src[0] = hue_low;
        h_div_src[0]  = hue_div;
        s_rem_src[0]  = sat_rem;
        s_word_src[0] = sat_low;
        s_div_src[0]  = sat_div;
        bright_src[0] = bright_in;
        gray_src[0]   = gray_in;
        for (int k = 1; k < NS; k++)
        begin
            valid_src[k]  = valid_reg[k-1];
            h_rem_src[k]  = h_rem_reg[k-1];
            h_word_src[k] = h_word_reg[k-1];
            h_div_src[k]  = h_div_reg[k-1];
            s_rem_src[k]  = s_rem_reg[k-1];
            s_word_src[k] = s_word_reg[k-1];
            s_div_src[k]  = s_div_reg[k-1];
            bright_src[k] = bright_reg[k-1];
            gray_src[k]   = gray_reg[k-1];
        end
    end

    // One restoring step per stage: shift in the next dividend bit, subtract
    // when it fits, shift the quotient bit in at the bottom of the word.
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            h_trial[k]     = {h_rem_src[k], h_word_src[k][QW-1]};
            h_ge[k]        = h_trial[k] >= {1'b0, h_div_src[k]};
            h_rem_next[k]  = h_ge[k] ? CW'(h_trial[k] - {1'b0, h_div_src[k]})
                                     : h_trial[k][CW-1:0];
            h_word_next[k] = {h_word_src[k][QW-2:0], h_ge[k]};

            s_trial[k]     = {s_rem_src[k], s_word_src[k][QW-1]};
            s_ge[k]        = s_trial[k] >= {1'b0, s_div_src[k]};
            s_rem_next[k]  = s_ge[k] ? CW'(s_trial[k] - {1'b0, s_div_src[k]})
                                     : s_trial[k][CW-1:0];
            s_word_next[k] = {s_word_src[k][QW-2:0], s_ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (ready[k])
            begin
                h_rem_reg[k]  <= h_rem_next[k];
                h_word_reg[k] <= h_word_next[k];
                h_div_reg[k]  <= h_div_src[k];
                s_rem_reg[k]  <= s_rem_next[k];
                s_word_reg[k] <= s_word_next[k];
                s_div_reg[k]  <= s_div_src[k];
                bright_reg[k] <= bright_src[k];
                gray_reg[k]   <= gray_src[k];
            end
        end
    end

    assign dn_valid   = valid_reg[NS-1];
    assign hue_q      = h_word_reg[NS-1];
    assign sat_q      = s_word_reg[NS-1];
    assign bright_out = bright_reg[NS-1];
    assign gray_out   = gray_reg[NS-1];

    // Remainders never reach the divisor if the front end seeded them right
    a_hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-1] |-> (h_rem_reg[NS-1] < h_div_reg[NS-1]))
        else $error("hue remainder not below divisor");

    a_sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-1] |-> (s_rem_reg[NS-1] < s_div_reg[NS-1]))
        else $error("saturation remainder not below divisor");

    a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dn_valid && gray_out) |-> (hue_q == '0 && sat_q == '0))
        else $error("gray pixel with nonzero hue or saturation");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        up_stall |-> (&valid_reg && dn_stall))
        else $error("upstream stalled while the pipe has a bubble");

endmodule

// ----- verif/hsv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_checker
// Watches the pixel and HSV channels of the converter, works out the HSV
// value of every accepted pixel and compares each accepted result against
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module hsv_checker
    import rth_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pixel_valid,
    input  logic                     pixel_stall,
    input  logic [CHANNEL_WIDTH-1:0] red,
    input  logic [CHANNEL_WIDTH-1:0] green,
    input  logic [CHANNEL_WIDTH-1:0] blue,
    input  logic                     hsv_valid,
    input  logic                     hsv_stall,
    input  logic [HUE_WIDTH-1:0]     hue,
    input  logic [SAT_WIDTH-1:0]     saturation,
    input  logic [CHANNEL_WIDTH-1:0] brightness,
    input  logic                     gray_flag,
    output int                       fail_count,
    output int                       pending_count,
    output int                       checked_count
);

    typedef struct packed {
        logic [HUE_WIDTH-1:0]     hue;
        logic [SAT_WIDTH-1:0]     sat;
        logic [CHANNEL_WIDTH-1:0] val;
        logic                     gray;
    } hsv_t;

    hsv_t expected_hsv[$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    function automatic hsv_t hsv_predict(input logic [CHANNEL_WIDTH-1:0] r,
                                         input logic [CHANNEL_WIDTH-1:0] g,
                                         input logic [CHANNEL_WIDTH-1:0] b);
        longint  rr, gg, bb, hi, lo, delta, diff, offset, num, scale;
        sector_t sector;
        hsv_t    res;
        rr    = r;
        gg    = g;
        bb    = b;
        scale = longint'(1) << FRACTION_BITS_DEFAULT;
        hi    = rr;
        lo    = rr;
        res   = '0;
        res.gray = (rr == gg) && (gg == bb);
        if (!res.gray)
        begin
            // strict compares keep the earlier channel on a tie
            sector = SECTOR_RED;
            if (hi < gg)
            begin
                hi     = gg;
                sector = SECTOR_GREEN;
            end
            if (hi < bb)
            begin
                hi     = bb;
                sector = SECTOR_BLUE;
            end
            if (lo > gg) lo = gg;
            if (lo > bb) lo = bb;
            delta = hi - lo;
            case (sector)
                SECTOR_RED:
                begin
                    diff   = gg - bb;
                    offset = 0;
                end
                SECTOR_GREEN:
                begin
                    diff   = bb - rr;
                    offset = GREEN_OFFSET;
                end
                default:
                begin
                    diff   = rr - gg;
                    offset = BLUE_OFFSET;
                end
            endcase
            num = DEG_PER_SECTOR * diff + offset * delta;
            // wrap a negative angle into the full turn
            if (num < 0)
                num = num + FULL_TURN * delta;
            res.hue = HUE_WIDTH'((num * scale) / delta);
            res.sat = SAT_WIDTH'((delta * SAT_SCALE * scale) / hi);
        end
        res.val = CHANNEL_WIDTH'(hi);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk)
    begin : watch
        hsv_t want;
        if (rst_n)
        begin
            if (hsv_valid && !hsv_stall)
            begin
                if (expected_hsv.size() == 0)
                    report_mismatch("result with nothing outstanding, hue", hue, -1);
                else
                begin
                    want = expected_hsv.pop_front();
                    checked_count = checked_count + 1;
                    if (hue !== want.hue)
                        report_mismatch("hue", hue, want.hue);
                    if (saturation !== want.sat)
                        report_mismatch("saturation", saturation, want.sat);
                    if (brightness !== want.val)
                        report_mismatch("brightness", brightness, want.val);
                    if (gray_flag !== want.gray)
                        report_mismatch("gray_flag", gray_flag, want.gray);
                end
            end
            if (pixel_valid && !pixel_stall)
                expected_hsv.push_back(hsv_predict(red, green, blue));
            pending_count = expected_hsv.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Pixel stream for the RGB to HSV converter: directed corner pixels (gray,
// black, white, pure primaries, channel ties, hue wrap), then random pixels
// under three idle profiles on both channels. A separate checker predicts
// and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench
    import rth_pkg::*;
();

    localparam int RANDOM_PER_PHASE = 235;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 200000;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     pixel_valid = 1'b0;
    logic                     pixel_stall;
    logic [CHANNEL_WIDTH-1:0] red         = '0;
    logic [CHANNEL_WIDTH-1:0] green       = '0;
    logic [CHANNEL_WIDTH-1:0] blue        = '0;
    logic                     hsv_valid;
    logic                     hsv_stall   = 1'b0;
    logic [HUE_WIDTH-1:0]     hue;
    logic [SAT_WIDTH-1:0]     saturation;
    logic [CHANNEL_WIDTH-1:0] brightness;
    logic                     gray_flag;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_count  = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    rgb_to_hsv_converter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .hsv_valid   (hsv_valid),
        .hsv_stall   (hsv_stall),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness),
        .gray_flag   (gray_flag)
    );

    hsv_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .hsv_valid     (hsv_valid),
        .hsv_stall     (hsv_stall),
        .hue           (hue),
        .saturation    (saturation),
        .brightness    (brightness),
        .gray_flag     (gray_flag),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        hsv_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    task automatic send_pixel(input int r, input int g, input int b);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= CHANNEL_WIDTH'(r);
        green       <= CHANNEL_WIDTH'(g);
        blue        <= CHANNEL_WIDTH'(b);
        // hold until the transfer happens
        do
            @(posedge clk);
        while (pixel_stall);
        sent_count = sent_count + 1;
    endtask

    function automatic int clamp_channel(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    task automatic send_random_pixel();
        int mode, base, r, g, b;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, 255);
        r    = $urandom_range(0, 255);
        g    = $urandom_range(0, 255);
        b    = $urandom_range(0, 255);
        case (mode)
            6:
            begin
                // near gray: tiny spread around one level
                r = clamp_channel(base + $urandom_range(0, 4) - 2);
                g = clamp_channel(base + $urandom_range(0, 4) - 2);
                b = clamp_channel(base + $urandom_range(0, 4) - 2);
            end
            7:
            begin
                // two channels tied
                case ($urandom_range(0, 2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            8:
            begin
                // push channels to the rails
                if ($urandom_range(0, 1)) r = $urandom_range(0, 1) * 255;
                if ($urandom_range(0, 1)) g = $urandom_range(0, 1) * 255;
                if ($urandom_range(0, 1)) b = $urandom_range(0, 1) * 255;
            end
            9:
            begin
                r = base;
                g = base;
                b = base;
            end
            default:
            begin
            end
        endcase
        send_pixel(r, g, b);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 10;
        rx_idle_pct = 56;

        // gray, black and white
        send_pixel(0, 0, 0);
        send_pixel(255, 255, 255);
        send_pixel(128, 128, 128);
        send_pixel(1, 1, 1);
        // pure primaries
        send_pixel(255, 0, 0);
        send_pixel(0, 255, 0);
        send_pixel(0, 0, 255);
        // ties between the largest channels
        send_pixel(255, 255, 0);
        send_pixel(0, 255, 255);
        send_pixel(255, 0, 255);
        send_pixel(1, 1, 0);
        // red sector with blue above green: hue wraps
        send_pixel(255, 0, 1);
        send_pixel(255, 0, 128);
        send_pixel(1, 0, 0);
        send_pixel(0, 0, 1);
        send_pixel(255, 254, 254);
        send_pixel(254, 255, 255);
        send_pixel(0, 1, 1);
        send_pixel(200, 100, 50);
        send_pixel(50, 200, 100);
        send_pixel(100, 50, 200);
        send_pixel(170, 85, 255);

        repeat (RANDOM_PER_PHASE) send_random_pixel();

        tx_idle_pct = 56;
        rx_idle_pct = 10;
        repeat (RANDOM_PER_PHASE) send_random_pixel();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_pixel();

        @(negedge clk);
        pixel_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d pixels (directed corners, then random under three idle profiles)",
                 sent_count);
        $display("checked %0d HSV results, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
